[rtl/tlg_pkg.sv]
// shared types, constants and tables of the turtle line generator
package tlg_pkg;

	localparam int STACK_DEPTH  = 64;
	localparam int CORDIC_STEPS = 16;

	localparam int STACK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int STEP_W   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int ATAN_IW  = 5;

	localparam int POS_W   = 32;
	localparam int POINT_W = 3 * POS_W;
	localparam int LEN_W   = 24;
	localparam int AMT_W   = 16;
	localparam int HEAD_W  = 15;
	localparam int TURN_W  = 17;
	localparam int ANG_W   = 32;
	localparam int GAIN_W  = 31;
	localparam int PROD_W  = LEN_W + GAIN_W;
	localparam int XY_W    = 42;
	localparam int RND_W   = XY_W + 2;

	localparam logic [HEAD_W-1:0] HEADING_QUARTER = HEAD_W'(5760);
	localparam logic [HEAD_W-1:0] HEADING_HALF    = HEAD_W'(11520);
	localparam logic [HEAD_W-1:0] HEADING_3QUART  = HEAD_W'(17280);
	localparam logic signed [TURN_W-1:0] TURN_FULL = TURN_W'(23040);
	localparam logic signed [TURN_W-1:0] TURN_2FULL = TURN_W'(46080);
	localparam logic signed [GAIN_W-1:0] GAIN_INV_Q30 = GAIN_W'(652032875);
	localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(2048);

	localparam int IN_DATA_W  = 136;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 168;
	localparam int OUT_USER_W = 2;

	typedef enum logic [2:0] {
		CMD_START,
		CMD_FORWARD,
		CMD_LEFT,
		CMD_RIGHT,
		CMD_PEN_UP,
		CMD_PEN_DOWN,
		CMD_PUSH,
		CMD_POP
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROT,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic rot;
		logic commit;
	} ctrl_t;

	typedef struct packed {
		logic last_step;
	} status_t;

	function automatic logic signed [ANG_W-1:0] atan_lut(input logic [ATAN_IW-1:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0:    v = ANG_W'(47185920);
			5'd1:    v = ANG_W'(27855475);
			5'd2:    v = ANG_W'(14718068);
			5'd3:    v = ANG_W'(7471121);
			5'd4:    v = ANG_W'(3750058);
			5'd5:    v = ANG_W'(1876857);
			5'd6:    v = ANG_W'(938658);
			5'd7:    v = ANG_W'(469357);
			5'd8:    v = ANG_W'(234682);
			5'd9:    v = ANG_W'(117342);
			5'd10:   v = ANG_W'(58671);
			5'd11:   v = ANG_W'(29335);
			5'd12:   v = ANG_W'(14668);
			5'd13:   v = ANG_W'(7334);
			5'd14:   v = ANG_W'(3667);
			5'd15:   v = ANG_W'(1833);
			5'd16:   v = ANG_W'(917);
			5'd17:   v = ANG_W'(458);
			5'd18:   v = ANG_W'(229);
			5'd19:   v = ANG_W'(115);
			5'd20:   v = ANG_W'(57);
			5'd21:   v = ANG_W'(29);
			5'd22:   v = ANG_W'(14);
			5'd23:   v = ANG_W'(7);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/tlg_ram.sv]
// generic single write port ram with registered read
module tlg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/tlg_ctrl.sv]
// controller state machine of the turtle line generator
module tlg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tlg_pkg::cmd_t     in_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output tlg_pkg::ctrl_t    ctrl,
	input  tlg_pkg::status_t  status
);

	tlg_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		case (state_q)
			tlg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load_in = 1'b1;
					state_d = (in_cmd == tlg_pkg::CMD_FORWARD) ? tlg_pkg::ST_MUL
						: tlg_pkg::ST_COMMIT;
				end
			end
			tlg_pkg::ST_MUL: begin
				ctrl.mul = 1'b1;
				state_d  = tlg_pkg::ST_ROT;
			end
			tlg_pkg::ST_ROT: begin
				ctrl.rot = 1'b1;
				if (status.last_step) begin
					state_d = tlg_pkg::ST_COMMIT;
				end
			end
			tlg_pkg::ST_COMMIT: begin
				if (!out_valid_q || out_ready) begin
					ctrl.commit = 1'b1;
					state_d     = tlg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tlg_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/tlg_datapath.sv]
// datapath: turtle state, cordic unit, point stack and result register
module tlg_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tlg_pkg::ctrl_t                         ctrl,
	output tlg_pkg::status_t                       status,
	input  tlg_pkg::cmd_t                          in_cmd,
	input  logic signed [tlg_pkg::LEN_W-1:0]        in_step_length,
	input  logic signed [tlg_pkg::AMT_W-1:0]        in_turn_amount,
	input  logic [tlg_pkg::POS_W-1:0]              in_start_x,
	input  logic [tlg_pkg::POS_W-1:0]              in_start_y,
	input  logic [tlg_pkg::POS_W-1:0]              in_start_z,
	output logic                                   out_line_drawn,
	output logic [tlg_pkg::POS_W-1:0]              out_from_x,
	output logic [tlg_pkg::POS_W-1:0]              out_from_y,
	output logic [tlg_pkg::POS_W-1:0]              out_to_x,
	output logic [tlg_pkg::POS_W-1:0]              out_to_y,
	output logic [tlg_pkg::POS_W-1:0]              out_to_z,
	output logic [tlg_pkg::CNT_W-1:0]              out_stack_level,
	output logic                                   out_overflow
);

	// latched command
	tlg_pkg::cmd_t                          cmd_q;
	logic signed [tlg_pkg::LEN_W-1:0]       len_q;
	logic signed [tlg_pkg::AMT_W-1:0]       amt_q;
	logic [tlg_pkg::POS_W-1:0]              sx_q, sy_q, sz_q;

	// turtle state
	logic [tlg_pkg::POS_W-1:0]              pos_x_q, pos_y_q, pos_z_q;
	logic [tlg_pkg::HEAD_W-1:0]             heading_q;
	logic                                   pen_raised_q;
	logic [tlg_pkg::CNT_W-1:0]              cnt_q;

	// cordic
	logic signed [tlg_pkg::XY_W-1:0]        x_q, y_q;
	logic signed [tlg_pkg::ANG_W-1:0]       z_q;
	logic [1:0]                             quad_q;
	logic [tlg_pkg::STEP_W-1:0]             step_q;

	logic [1:0]                             quad;
	logic [tlg_pkg::HEAD_W-1:0]             residue;
	logic signed [tlg_pkg::PROD_W-1:0]      prod;
	logic signed [tlg_pkg::XY_W-1:0]        shx, shy;
	logic signed [tlg_pkg::ANG_W-1:0]       atan_v;

	logic signed [tlg_pkg::XY_W-1:0]        cval, sval;
	logic signed [tlg_pkg::RND_W-1:0]       crnd, srnd;
	logic [tlg_pkg::POS_W-1:0]              dx, dy;

	logic signed [tlg_pkg::TURN_W-1:0]      turn_sum;
	logic [tlg_pkg::HEAD_W-1:0]             turn_res;

	logic                                   full, empty;
	logic [tlg_pkg::POINT_W-1:0]            rd_point;
	logic [tlg_pkg::CNT_W-1:0]              cnt_m1;
	logic                                   push_we;

	logic [tlg_pkg::POS_W-1:0]              nx, ny, nz;
	logic [tlg_pkg::HEAD_W-1:0]             nhead;
	logic                                   npen;
	logic [tlg_pkg::CNT_W-1:0]              ncnt;
	logic                                   ndrawn, novf;

	// heading split into quadrant and residue
	always_comb begin
		if (heading_q >= tlg_pkg::HEADING_3QUART) begin
			quad    = 2'd3;
			residue = heading_q - tlg_pkg::HEADING_3QUART;
		end else if (heading_q >= tlg_pkg::HEADING_HALF) begin
			quad    = 2'd2;
			residue = heading_q - tlg_pkg::HEADING_HALF;
		end else if (heading_q >= tlg_pkg::HEADING_QUARTER) begin
			quad    = 2'd1;
			residue = heading_q - tlg_pkg::HEADING_QUARTER;
		end else begin
			quad    = 2'd0;
			residue = heading_q;
		end
	end

	assign prod   = len_q * tlg_pkg::GAIN_INV_Q30;
	assign shx    = x_q >>> step_q;
	assign shy    = y_q >>> step_q;
	assign atan_v = tlg_pkg::atan_lut(tlg_pkg::ATAN_IW'(step_q));

	assign status.last_step = (step_q == tlg_pkg::STEP_W'(tlg_pkg::CORDIC_STEPS - 1));

	// quadrant map and rounding to q16.16
	always_comb begin
		case (quad_q)
			2'd0:    begin cval = x_q;  sval = y_q;  end
			2'd1:    begin cval = -y_q; sval = x_q;  end
			2'd2:    begin cval = -x_q; sval = -y_q; end
			default: begin cval = y_q;  sval = -x_q; end
		endcase
		crnd = tlg_pkg::RND_W'(cval) + tlg_pkg::ROUND_HALF;
		srnd = tlg_pkg::RND_W'(sval) + tlg_pkg::ROUND_HALF;
		dx   = crnd[tlg_pkg::POS_W+11:12];
		dy   = srnd[tlg_pkg::POS_W+11:12];
	end

	// heading update reduced to one full turn
	always_comb begin
		if (cmd_q == tlg_pkg::CMD_LEFT) begin
			turn_sum = $signed({2'b00, heading_q}) + tlg_pkg::TURN_W'(amt_q);
		end else begin
			turn_sum = $signed({2'b00, heading_q}) - tlg_pkg::TURN_W'(amt_q);
		end
		if (turn_sum < -tlg_pkg::TURN_FULL) begin
			turn_res = tlg_pkg::HEAD_W'(turn_sum + tlg_pkg::TURN_2FULL);
		end else if (turn_sum < 0) begin
			turn_res = tlg_pkg::HEAD_W'(turn_sum + tlg_pkg::TURN_FULL);
		end else if (turn_sum < tlg_pkg::TURN_FULL) begin
			turn_res = tlg_pkg::HEAD_W'(turn_sum);
		end else if (turn_sum < tlg_pkg::TURN_2FULL) begin
			turn_res = tlg_pkg::HEAD_W'(turn_sum - tlg_pkg::TURN_FULL);
		end else begin
			turn_res = tlg_pkg::HEAD_W'(turn_sum - tlg_pkg::TURN_2FULL);
		end
	end

	assign full    = (cnt_q >= tlg_pkg::CNT_W'(tlg_pkg::STACK_DEPTH));
	assign empty   = (cnt_q == '0);
	assign cnt_m1  = cnt_q - 1'b1;
	assign push_we = ctrl.commit && (cmd_q == tlg_pkg::CMD_PUSH) && !full;

	tlg_ram #(
		.WIDTH(tlg_pkg::POINT_W),
		.DEPTH(tlg_pkg::STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (push_we),
		.waddr (cnt_q[tlg_pkg::STACK_AW-1:0]),
		.wdata ({pos_z_q, pos_y_q, pos_x_q}),
		.raddr (cnt_m1[tlg_pkg::STACK_AW-1:0]),
		.rdata (rd_point)
	);

	// next turtle state at commit
	always_comb begin
		nx     = pos_x_q;
		ny     = pos_y_q;
		nz     = pos_z_q;
		nhead  = heading_q;
		npen   = pen_raised_q;
		ncnt   = cnt_q;
		ndrawn = 1'b0;
		novf   = 1'b0;
		case (cmd_q)
			tlg_pkg::CMD_START: begin
				ncnt  = '0;
				nhead = '0;
				nx    = sx_q;
				ny    = sy_q;
				nz    = sz_q;
			end
			tlg_pkg::CMD_FORWARD: begin
				nx     = pos_x_q + dx;
				ny     = pos_y_q + dy;
				ndrawn = !pen_raised_q;
			end
			tlg_pkg::CMD_LEFT, tlg_pkg::CMD_RIGHT: begin
				nhead = turn_res;
			end
			tlg_pkg::CMD_PEN_UP: begin
				npen = 1'b1;
			end
			tlg_pkg::CMD_PEN_DOWN: begin
				npen = 1'b0;
			end
			tlg_pkg::CMD_PUSH: begin
				if (full) begin
					novf = 1'b1;
				end else begin
					ncnt = cnt_q + 1'b1;
				end
			end
			tlg_pkg::CMD_POP: begin
				if (!empty) begin
					ncnt = cnt_m1;
					nx   = rd_point[tlg_pkg::POS_W-1:0];
					ny   = rd_point[2*tlg_pkg::POS_W-1:tlg_pkg::POS_W];
					nz   = rd_point[3*tlg_pkg::POS_W-1:2*tlg_pkg::POS_W];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			pos_z_q      <= '0;
			heading_q    <= '0;
			pen_raised_q <= 1'b0;
			cnt_q        <= '0;
			step_q       <= '0;
			cmd_q        <= tlg_pkg::CMD_START;
		end else begin
			if (ctrl.load_in) begin
				cmd_q <= in_cmd;
			end
			if (ctrl.mul) begin
				step_q <= '0;
			end else if (ctrl.rot) begin
				step_q <= step_q + 1'b1;
			end
			if (ctrl.commit) begin
				pos_x_q      <= nx;
				pos_y_q      <= ny;
				pos_z_q      <= nz;
				heading_q    <= nhead;
				pen_raised_q <= npen;
				cnt_q        <= ncnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			len_q <= in_step_length;
			amt_q <= in_turn_amount;
			sx_q  <= in_start_x;
			sy_q  <= in_start_y;
			sz_q  <= in_start_z;
		end
		if (ctrl.mul) begin
			x_q    <= tlg_pkg::XY_W'(prod >>> 14);
			y_q    <= '0;
			z_q    <= tlg_pkg::ANG_W'({residue, 14'd0});
			quad_q <= quad;
		end else if (ctrl.rot) begin
			if (!z_q[tlg_pkg::ANG_W-1]) begin
				x_q <= x_q - shy;
				y_q <= y_q + shx;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + shy;
				y_q <= y_q - shx;
				z_q <= z_q + atan_v;
			end
		end
		if (ctrl.commit) begin
			out_line_drawn  <= ndrawn;
			out_from_x      <= pos_x_q;
			out_from_y      <= pos_y_q;
			out_to_x        <= nx;
			out_to_y        <= ny;
			out_to_z        <= nz;
			out_stack_level <= ncnt;
			out_overflow    <= novf;
		end
	end

endmodule

[rtl/turtle_line_generator_core.sv]
// top level of the turtle line generator
// a forward command runs multiply, 16 cordic iterations and commit; every
// other command goes straight from accept to commit
// a new command is accepted only once the previous one has committed its
// result, and commit waits while the output holds an unaccepted result
// reset: arst_n clears position, heading, pen, stack count and handshakes
// at once; stack ram contents stay undefined, no clearing pass
module turtle_line_generator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// step_length, turn_amount, start_x, start_y, start_z
	input  logic [tlg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// cmd
	input  logic [tlg_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// from_x, from_y, to_x, to_y, to_z, stack_level, zero pad
	output logic [tlg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// line_drawn, overflow
	output logic [tlg_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

	tlg_pkg::ctrl_t   ctrl;
	tlg_pkg::status_t status;
	tlg_pkg::cmd_t    in_cmd;

	logic                                line_drawn;
	logic [tlg_pkg::POS_W-1:0]           from_x, from_y, to_x, to_y, to_z;
	logic [tlg_pkg::CNT_W-1:0]           stack_level;
	logic                                overflow;

	assign in_cmd = tlg_pkg::cmd_t'(s_axis_tuser);

	tlg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (in_cmd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctrl      (ctrl),
		.status    (status)
	);

	tlg_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.status          (status),
		.in_cmd          (in_cmd),
		.in_step_length  (s_axis_tdata[23:0]),
		.in_turn_amount  (s_axis_tdata[39:24]),
		.in_start_x      (s_axis_tdata[71:40]),
		.in_start_y      (s_axis_tdata[103:72]),
		.in_start_z      (s_axis_tdata[135:104]),
		.out_line_drawn  (line_drawn),
		.out_from_x      (from_x),
		.out_from_y      (from_y),
		.out_to_x        (to_x),
		.out_to_y        (to_y),
		.out_to_z        (to_z),
		.out_stack_level (stack_level),
		.out_overflow    (overflow)
	);

	assign m_axis_tdata = {1'b0, stack_level, to_z, to_y, to_x, from_y, from_x};
	assign m_axis_tuser = {overflow, line_drawn};

endmodule

[test/turtle_line_generator_core_tb.sv]
// self-checking testbench of the turtle line generator core: directed table plus random commands
module turtle_line_generator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FULL_TURN    = 23040;
	localparam int QUARTER_TURN = 5760;
	localparam longint GAIN_Q30 = 652032875;
	localparam int ATAN_LEN     = 24;
	localparam int PHASES       = 4;
	localparam int RANDOM_PER_PHASE = 180;

	typedef struct {
		logic        drawn;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] tz;
		logic [6:0]  level;
		logic        ovf;
	} move_rec_t;

	typedef struct {
		tlg_pkg::cmd_t      cmd;
		logic signed [23:0] len;
		logic signed [15:0] amt;
		logic [31:0]        sx;
		logic [31:0]        sy;
		logic [31:0]        sz;
		bit                 known;
		move_rec_t          want;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [tlg_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [tlg_pkg::IN_USER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [tlg_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [tlg_pkg::OUT_USER_W-1:0] m_axis_tuser;

	// turtle state as the predictor sees it
	logic [31:0] pos_x, pos_y, pos_z;
	int          heading;
	bit          pen_up;
	logic [31:0] saved_x [tlg_pkg::STACK_DEPTH];
	logic [31:0] saved_y [tlg_pkg::STACK_DEPTH];
	logic [31:0] saved_z [tlg_pkg::STACK_DEPTH];
	int          saved_count;

	longint atan_deg20 [ATAN_LEN] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
		938658, 469357, 234682, 117342, 58671, 29335,
		14668, 7334, 3667, 1833, 917, 458,
		229, 115, 57, 29, 14, 7
	};

	move_rec_t pending_moves [$];
	cmd_row_t  cmd_table [$];
	int        mismatches = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;

	turtle_line_generator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int wrap_heading(input int h);
		int r;
		r = h % FULL_TURN;
		if (r < 0)
			r += FULL_TURN;
		return r;
	endfunction

	// cos/sin step of a forward move, rounded to q16.16
	function automatic void cordic_delta(input logic signed [23:0] len,
			output logic [31:0] dx, output logic [31:0] dy);
		longint x, y, z, nx, c, s;
		int     q;
		q = heading / QUARTER_TURN;
		z = longint'(heading % QUARTER_TURN) * 16384;
		x = (longint'(len) * GAIN_Q30) >>> 14;
		y = 0;
		for (int i = 0; i < tlg_pkg::CORDIC_STEPS && i < ATAN_LEN; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - atan_deg20[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + atan_deg20[i];
			end
			x = nx;
		end
		case (q)
			0: begin
				c = x;
				s = y;
			end
			1: begin
				c = -y;
				s = x;
			end
			2: begin
				c = -x;
				s = -y;
			end
			default: begin
				c = y;
				s = -x;
			end
		endcase
		dx = 32'((c + 2048) >>> 12);
		dy = 32'((s + 2048) >>> 12);
	endfunction

	function automatic move_rec_t apply_command(input tlg_pkg::cmd_t cmd,
			input logic signed [23:0] len, input logic signed [15:0] amt,
			input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz);
		move_rec_t   r;
		logic [31:0] dx, dy;
		r.drawn = 1'b0;
		r.ovf   = 1'b0;
		r.fx    = pos_x;
		r.fy    = pos_y;
		case (cmd)
			tlg_pkg::CMD_START: begin
				saved_count = 0;
				heading = 0;
				pos_x = sx;
				pos_y = sy;
				pos_z = sz;
			end
			tlg_pkg::CMD_FORWARD: begin
				cordic_delta(len, dx, dy);
				pos_x = pos_x + dx;
				pos_y = pos_y + dy;
				r.drawn = !pen_up;
			end
			tlg_pkg::CMD_LEFT:     heading = wrap_heading(heading + int'(amt));
			tlg_pkg::CMD_RIGHT:    heading = wrap_heading(heading - int'(amt));
			tlg_pkg::CMD_PEN_UP:   pen_up = 1'b1;
			tlg_pkg::CMD_PEN_DOWN: pen_up = 1'b0;
			tlg_pkg::CMD_PUSH: begin
				if (saved_count < tlg_pkg::STACK_DEPTH) begin
					saved_x[saved_count] = pos_x;
					saved_y[saved_count] = pos_y;
					saved_z[saved_count] = pos_z;
					saved_count++;
				end else begin
					r.ovf = 1'b1;
				end
			end
			default: begin
				if (saved_count > 0) begin
					saved_count--;
					pos_x = saved_x[saved_count];
					pos_y = saved_y[saved_count];
					pos_z = saved_z[saved_count];
				end
			end
		endcase
		r.tx = pos_x;
		r.ty = pos_y;
		r.tz = pos_z;
		r.level = 7'(saved_count);
		return r;
	endfunction

	function automatic move_rec_t make_move(input logic drawn, input logic [31:0] fx,
			input logic [31:0] fy, input logic [31:0] tx, input logic [31:0] ty,
			input logic [31:0] tz, input logic [6:0] level, input logic ovf);
		move_rec_t r;
		r.drawn = drawn;
		r.fx = fx;
		r.fy = fy;
		r.tx = tx;
		r.ty = ty;
		r.tz = tz;
		r.level = level;
		r.ovf = ovf;
		return r;
	endfunction

	function automatic void add_row(input tlg_pkg::cmd_t cmd, input logic signed [23:0] len,
			input logic signed [15:0] amt, input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] sz, input bit known, input move_rec_t want);
		cmd_row_t row;
		row.cmd = cmd;
		row.len = len;
		row.amt = amt;
		row.sx = sx;
		row.sy = sy;
		row.sz = sz;
		row.known = known;
		row.want = want;
		cmd_table.insert(cmd_table.size(), row);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_move(input logic [tlg_pkg::OUT_DATA_W-1:0] data,
			input logic [tlg_pkg::OUT_USER_W-1:0] user);
		move_rec_t want;
		if (pending_moves.size() == 0) begin
			$display("%0t: unexpected transaction expected none got %h %h", $time, user, data);
			mismatches++;
		end else begin
			want = pending_moves.pop_front();
			check_field("line_drawn", 32'(want.drawn), 32'(user[0]));
			check_field("overflow", 32'(want.ovf), 32'(user[1]));
			check_field("from_x", want.fx, data[31:0]);
			check_field("from_y", want.fy, data[63:32]);
			check_field("to_x", want.tx, data[95:64]);
			check_field("to_y", want.ty, data[127:96]);
			check_field("to_z", want.tz, data[159:128]);
			check_field("stack_level", 32'(want.level), 32'(data[166:160]));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_move(m_axis_tdata, m_axis_tuser);
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic issue(input tlg_pkg::cmd_t cmd, input logic signed [23:0] len,
			input logic signed [15:0] amt, input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] sz, input bit known, input move_rec_t want);
		move_rec_t pred;
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {sz, sy, sx, amt, len};
		s_axis_tuser  <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pred = apply_command(cmd, len, amt, sx, sy, sz);
		pending_moves.insert(pending_moves.size(), known ? want : pred);
	endtask

	task automatic random_item(input tlg_pkg::cmd_t cmd);
		logic signed [23:0] len;
		logic signed [15:0] amt;
		logic [31:0]        sx, sy, sz;
		move_rec_t          none;
		len = 24'($urandom());
		case ($urandom_range(7))
			0, 1:    ;
			2:       len = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
			default: len = 24'(int'($urandom_range(16383)) - 8192);
		endcase
		case ($urandom_range(9))
			0:       amt = 16'($urandom());
			1:       amt = 16'(QUARTER_TURN * (int'($urandom_range(8)) - 4));
			default: amt = 16'(int'($urandom_range(2 * FULL_TURN)) - FULL_TURN);
		endcase
		sx = $urandom();
		sy = $urandom();
		sz = $urandom();
		if ($urandom_range(3) == 0) begin
			sx = {{16{sx[31]}}, sx[15:0]};
			sy = {{16{sy[31]}}, sy[15:0]};
		end
		none = make_move(1'b0, '0, '0, '0, '0, '0, 7'd0, 1'b0);
		issue(cmd, len, amt, sx, sy, sz, 1'b0, none);
	endtask

	function automatic tlg_pkg::cmd_t pick_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return tlg_pkg::CMD_START;
		else if (r < 40)
			return tlg_pkg::CMD_FORWARD;
		else if (r < 52)
			return tlg_pkg::CMD_LEFT;
		else if (r < 62)
			return tlg_pkg::CMD_RIGHT;
		else if (r < 68)
			return tlg_pkg::CMD_PEN_UP;
		else if (r < 75)
			return tlg_pkg::CMD_PEN_DOWN;
		else if (r < 88)
			return tlg_pkg::CMD_PUSH;
		return tlg_pkg::CMD_POP;
	endfunction

	initial begin
		move_rec_t none;
		none = make_move(1'b0, '0, '0, '0, '0, '0, 7'd0, 1'b0);
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		heading = 0;
		pen_up = 1'b0;
		saved_count = 0;

		add_row(tlg_pkg::CMD_PEN_UP, 24'sh7fffff, 16'sh7fff, '1, '1, '1, 1'b1, none);
		add_row(tlg_pkg::CMD_POP, 24'sh800000, 16'sh8000, '1, '1, '1, 1'b1, none);
		add_row(tlg_pkg::CMD_FORWARD, 24'sh0, 16'sh0, '0, '0, '0, 1'b1, none);
		add_row(tlg_pkg::CMD_PEN_DOWN, 24'sh0, 16'sh0, '0, '0, '0, 1'b1, none);
		add_row(tlg_pkg::CMD_START, 24'sh0, 16'sh0, 32'h7fffffff, 32'h80000000,
			32'hffffffff, 1'b1,
			make_move(1'b0, '0, '0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 7'd0,
				1'b0));
		add_row(tlg_pkg::CMD_FORWARD, 24'sh7fffff, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_LEFT, 24'sh0, 16'(QUARTER_TURN), '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_FORWARD, 24'sh800000, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_LEFT, 24'sh0, 16'(QUARTER_TURN), '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_FORWARD, 24'sh001000, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_LEFT, 24'sh0, 16'(QUARTER_TURN), '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_FORWARD, 24'sh001000, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_RIGHT, 24'sh0, 16'sh8000, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_LEFT, 24'sh0, 16'sh7fff, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_LEFT, 24'sh0, 16'(FULL_TURN), '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_RIGHT, 24'sh0, 16'(FULL_TURN), '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_PUSH, 24'sh0, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_FORWARD, 24'sh003039, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_PUSH, 24'sh0, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_POP, 24'sh0, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_POP, 24'sh0, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_START, 24'sh5a5a5a, 16'sh5a5a, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_RIGHT, 24'sh0, 16'sh1, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_FORWARD, 24'sh001000, 16'sh0, '0, '0, '0, 1'b0, none);
		add_row(tlg_pkg::CMD_PEN_UP, 24'sh0, 16'sh0, '0, '0, '0, 1'b0, none);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (cmd_table[i])
			issue(cmd_table[i].cmd, cmd_table[i].len, cmd_table[i].amt, cmd_table[i].sx,
				cmd_table[i].sy, cmd_table[i].sz, cmd_table[i].known, cmd_table[i].want);

		for (int phase = 0; phase < PHASES; phase++) begin
			// hold off until the block has drained
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while (pending_moves.size() != 0);
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 86;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 86;
				end
				default: begin
					idle_pct = 28;
					stall_pct = 28;
				end
			endcase
			repeat (RANDOM_PER_PHASE)
				random_item(pick_cmd());
			if (phase % 2 == 0) begin
				// fill the stack past full, then pop it back down; on average one in eight of those items is a forward move
				repeat (tlg_pkg::STACK_DEPTH + 6)
					random_item(tlg_pkg::CMD_PUSH);
				repeat (tlg_pkg::STACK_DEPTH + 8)
					random_item($urandom_range(7) == 0 ? tlg_pkg::CMD_FORWARD
						: tlg_pkg::CMD_POP);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_moves.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_moves.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/tlg_pkg.sv
rtl/tlg_ram.sv
rtl/tlg_ctrl.sv
rtl/tlg_datapath.sv
rtl/turtle_line_generator_core.sv
test/turtle_line_generator_core_tb.sv
